@@ hdl/kmc_pkg.sv @@
// ----------------------------------------------------------------------------
// kmc_pkg
// Shared types and constants for the 2D k-means clustering core.
// ----------------------------------------------------------------------------
package kmc_pkg;

  // Storage sizes and number format
  localparam int MAX_POINTS  = 64;
  localparam int MAX_CENTERS = 16;
  localparam int FRAC_BITS   = 8;

  localparam int PT_IDX_W = 6;              // point index
  localparam int PT_CNT_W = PT_IDX_W + 1;   // points loaded, 0..64
  localparam int CT_IDX_W = 4;              // center index
  localparam int CT_CNT_W = CT_IDX_W + 1;   // centers loaded, 0..16
  localparam int COORD_W  = 16;
  localparam int CTR_W    = COORD_W + FRAC_BITS;     // Q16.8 center
  localparam int DIFF_W   = CTR_W + 1;
  localparam int SQ_W     = 2 * DIFF_W;
  localparam int DIST_W   = SQ_W + 1;
  localparam int SUM_W    = COORD_W + PT_IDX_W;      // per-cluster sum
  localparam int DVD_W    = SUM_W + FRAC_BITS;       // scaled sum
  localparam int ITER_W   = 16;
  localparam int OP_W     = 2;

  localparam logic [ITER_W-1:0] MAX_ITER_RESET = 16'd100;

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOAD_POINT  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_CENTER = 2'd1;
  localparam logic [OP_W-1:0] OP_RUN         = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load_point;
    logic load_center;
    logic run_init;
    logic pass_begin;
    logic pt_read;
    logic pt_latch;
    logic c_read;
    logic c_diff;
    logic c_square;
    logic c_sum;
    logic c_compare;
    logic pt_commit;
    logic upd_begin;
    logic div_start_x;
    logic div_start_y;
    logic wr_cx;
    logic wr_cy;
    logic upd_next;
    logic iter_inc;
    logic out_begin;
    logic emit;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic no_points;
    logic no_pass;
    logic cmp_init;
    logic j_end;
    logic pt_last;
    logic changed;
    logic count_nz;
    logic div_done;
    logic it_last;
  } stat_t;

endpackage

@@ hdl/kmc_divider.sv @@
// ----------------------------------------------------------------------------
// kmc_divider
// Signed by unsigned restoring divider, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module kmc_divider (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [kmc_pkg::DVD_W-1:0] dividend,
  input  logic [kmc_pkg::PT_CNT_W-1:0]     divisor,
  output logic                             done,
  output logic signed [kmc_pkg::CTR_W-1:0] quotient
);

  localparam int CNT_W = $clog2(kmc_pkg::DVD_W + 1);
  localparam int REM_W = kmc_pkg::PT_CNT_W + 1;

  logic                          active;
  logic [CNT_W-1:0]              count;
  logic                          neg;
  logic [kmc_pkg::DVD_W-1:0]     quo;
  logic [REM_W-1:0]              rem;
  logic [kmc_pkg::PT_CNT_W-1:0]  dvs;
  logic [REM_W-1:0]              rem_sh;
  logic [kmc_pkg::DVD_W-1:0]     q_signed;

  // one restoring step
  assign rem_sh   = {rem[REM_W-2:0], quo[kmc_pkg::DVD_W-1]};
  assign q_signed = neg ? (~quo + 1'b1) : quo;
  assign quotient = q_signed[kmc_pkg::CTR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      count  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        count  <= CNT_W'(kmc_pkg::DVD_W);
        neg    <= dividend[kmc_pkg::DVD_W-1];
        quo    <= dividend[kmc_pkg::DVD_W-1] ? (~dividend + 1'b1) : dividend;
        rem    <= '0;
        dvs    <= divisor;
      end else if (active) begin
        if (rem_sh >= {1'b0, dvs}) begin
          rem <= rem_sh - {1'b0, dvs};
          quo <= {quo[kmc_pkg::DVD_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[kmc_pkg::DVD_W-2:0], 1'b0};
        end
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

@@ hdl/kmc_datapath.sv @@
// ----------------------------------------------------------------------------
// kmc_datapath
// Point, center and assignment stores, distance unit, cluster sums,
// center update through the divider, and the result registers.
// ----------------------------------------------------------------------------
module kmc_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  kmc_pkg::cmd_t                       cmd,
  output kmc_pkg::stat_t                      stat,
  input  logic signed [kmc_pkg::COORD_W-1:0]  coord_x,
  input  logic signed [kmc_pkg::COORD_W-1:0]  coord_y,
  input  logic                                cfg_we,
  input  logic [kmc_pkg::ITER_W-1:0]          cfg_data,
  output logic                                strobe,
  output logic [kmc_pkg::PT_IDX_W-1:0]        point_index,
  output logic [kmc_pkg::CT_IDX_W-1:0]        cluster,
  output logic [kmc_pkg::ITER_W-1:0]          iterations,
  output logic                                last
);

  localparam int PAD = kmc_pkg::SUM_W - kmc_pkg::COORD_W;

  // stores
  logic signed [kmc_pkg::COORD_W-1:0] point_xs [kmc_pkg::MAX_POINTS];
  logic signed [kmc_pkg::COORD_W-1:0] point_ys [kmc_pkg::MAX_POINTS];
  logic [kmc_pkg::CT_IDX_W-1:0]       assigned_center [kmc_pkg::MAX_POINTS];
  logic signed [kmc_pkg::CTR_W-1:0]   center_xs [kmc_pkg::MAX_CENTERS];
  logic signed [kmc_pkg::CTR_W-1:0]   center_ys [kmc_pkg::MAX_CENTERS];
  logic signed [kmc_pkg::SUM_W-1:0]   sum_xs [kmc_pkg::MAX_CENTERS];
  logic signed [kmc_pkg::SUM_W-1:0]   sum_ys [kmc_pkg::MAX_CENTERS];
  logic [kmc_pkg::PT_CNT_W-1:0]       member_counts [kmc_pkg::MAX_CENTERS];

  logic [kmc_pkg::ITER_W-1:0]   max_iterations;
  logic [kmc_pkg::PT_CNT_W-1:0] points_loaded;
  logic [kmc_pkg::CT_CNT_W-1:0] centers_loaded;

  // run state
  logic [kmc_pkg::PT_IDX_W-1:0] pi;
  logic [kmc_pkg::CT_IDX_W-1:0] cj;
  logic [kmc_pkg::CT_IDX_W-1:0] caddr;
  logic [kmc_pkg::CT_IDX_W-1:0] best;
  logic [kmc_pkg::CT_IDX_W-1:0] prev;
  logic [kmc_pkg::ITER_W-1:0]   it;
  logic                         first_pass;
  logic                         no_pass;
  logic                         changed;
  logic                         cmp_init;

  // read data and distance pipeline
  logic signed [kmc_pkg::COORD_W-1:0] pd_x, pd_y;
  logic [kmc_pkg::CT_IDX_W-1:0]       ad;
  logic signed [kmc_pkg::CTR_W-1:0]   px, py, cd_x, cd_y;
  logic signed [kmc_pkg::DIFF_W-1:0]  dx, dy;
  logic [kmc_pkg::SQ_W-1:0]           sqx, sqy;
  logic [kmc_pkg::DIST_W-1:0]         cur_dist, bd;

  // divider
  logic signed [kmc_pkg::DVD_W-1:0] div_dividend;
  logic                             div_start;
  logic                             div_done;
  logic signed [kmc_pkg::CTR_W-1:0] div_q;

  assign div_start    = cmd.div_start_x | cmd.div_start_y;
  assign div_dividend = cmd.div_start_y ? {sum_ys[cj], {kmc_pkg::FRAC_BITS{1'b0}}}
                                        : {sum_xs[cj], {kmc_pkg::FRAC_BITS{1'b0}}};

  kmc_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (member_counts[cj]),
    .done     (div_done),
    .quotient (div_q)
  );

  // status
  always_comb begin
    stat.no_points = (points_loaded == '0);
    stat.no_pass   = (centers_loaded == '0) || (max_iterations == '0);
    stat.cmp_init  = cmp_init;
    stat.j_end     = (kmc_pkg::CT_CNT_W'(cj) == centers_loaded - 1'b1);
    stat.pt_last   = (kmc_pkg::PT_CNT_W'(pi) == points_loaded - 1'b1);
    stat.changed   = changed;
    stat.count_nz  = (member_counts[cj] != '0);
    stat.div_done  = div_done;
    stat.it_last   = (it + 1'b1 == max_iterations);
  end

  // configuration and load counters
  always_ff @(posedge clk) begin
    if (rst) begin
      max_iterations <= kmc_pkg::MAX_ITER_RESET;
      points_loaded  <= '0;
      centers_loaded <= '0;
    end else begin
      if (cfg_we) max_iterations <= cfg_data;
      if (cmd.load_point && points_loaded < kmc_pkg::PT_CNT_W'(kmc_pkg::MAX_POINTS))
        points_loaded <= points_loaded + 1'b1;
      if (cmd.load_center && centers_loaded < kmc_pkg::CT_CNT_W'(kmc_pkg::MAX_CENTERS))
        centers_loaded <= centers_loaded + 1'b1;
    end
  end

  // point store: written on load, read by index
  always_ff @(posedge clk) begin
    if (cmd.load_point && points_loaded < kmc_pkg::PT_CNT_W'(kmc_pkg::MAX_POINTS)) begin
      point_xs[points_loaded[kmc_pkg::PT_IDX_W-1:0]] <= coord_x;
      point_ys[points_loaded[kmc_pkg::PT_IDX_W-1:0]] <= coord_y;
    end
    if (cmd.pt_read) begin
      pd_x <= point_xs[pi];
      pd_y <= point_ys[pi];
    end
  end

  // assignment store
  always_ff @(posedge clk) begin
    if (cmd.pt_commit) assigned_center[pi] <= best;
    if (cmd.pt_read) ad <= assigned_center[pi];
  end

  // center stores: load writes at the fill count, update writes at cj
  always_ff @(posedge clk) begin
    if (cmd.load_center && centers_loaded < kmc_pkg::CT_CNT_W'(kmc_pkg::MAX_CENTERS)) begin
      center_xs[centers_loaded[kmc_pkg::CT_IDX_W-1:0]] <=
        {coord_x, {kmc_pkg::FRAC_BITS{1'b0}}};
      center_ys[centers_loaded[kmc_pkg::CT_IDX_W-1:0]] <=
        {coord_y, {kmc_pkg::FRAC_BITS{1'b0}}};
    end else begin
      if (cmd.wr_cx) center_xs[cj] <= div_q;
      if (cmd.wr_cy) center_ys[cj] <= div_q;
    end
    if (cmd.c_read) begin
      cd_x <= center_xs[caddr];
      cd_y <= center_ys[caddr];
    end
  end

  // distance pipeline: difference, square, sum
  always_ff @(posedge clk) begin
    if (cmd.c_diff) begin
      dx <= kmc_pkg::DIFF_W'(px) - kmc_pkg::DIFF_W'(cd_x);
      dy <= kmc_pkg::DIFF_W'(py) - kmc_pkg::DIFF_W'(cd_y);
    end
    if (cmd.c_square) begin
      sqx <= kmc_pkg::SQ_W'(dx * dx);
      sqy <= kmc_pkg::SQ_W'(dy * dy);
    end
    if (cmd.c_sum) cur_dist <= kmc_pkg::DIST_W'(sqx) + kmc_pkg::DIST_W'(sqy);
  end

  // assignment search: the previous assignment seeds the best distance, then
  // every center is compared in turn; there is no center-gap pruning here
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_init   <= 1'b0;
      changed    <= 1'b0;
      first_pass <= 1'b0;
      no_pass    <= 1'b0;
      it         <= '0;
      pi         <= '0;
      cj         <= '0;
    end else begin
      if (cmd.run_init) begin
        it         <= '0;
        first_pass <= 1'b1;
        no_pass    <= stat.no_pass;
      end
      if (cmd.pass_begin) begin
        pi      <= '0;
        changed <= 1'b0;
      end
      if (cmd.pt_latch) begin
        px       <= {pd_x, {kmc_pkg::FRAC_BITS{1'b0}}};
        py       <= {pd_y, {kmc_pkg::FRAC_BITS{1'b0}}};
        prev     <= first_pass ? '0 : ad;
        best     <= first_pass ? '0 : ad;
        caddr    <= first_pass ? '0 : ad;
        cmp_init <= 1'b1;
      end
      if (cmd.c_compare) begin
        if (cmp_init) begin
          bd       <= cur_dist;
          cj       <= '0;
          caddr    <= '0;
          cmp_init <= 1'b0;
        end else begin
          if (cur_dist < bd) begin
            best <= cj;
            bd   <= cur_dist;
          end
          cj    <= cj + 1'b1;
          caddr <= cj + 1'b1;
        end
      end
      if (cmd.pt_commit) begin
        if (best != prev) changed <= 1'b1;
        pi <= pi + 1'b1;
      end
      if (cmd.upd_begin) begin
        first_pass <= 1'b0;
        cj         <= '0;
      end
      if (cmd.upd_next) cj <= cj + 1'b1;
      if (cmd.iter_inc) it <= it + 1'b1;
      if (cmd.out_begin) pi <= '0;
      if (cmd.emit) pi <= pi + 1'b1;
    end
  end

  // cluster sums
  always_ff @(posedge clk) begin
    if (cmd.pass_begin) begin
      for (int k = 0; k < kmc_pkg::MAX_CENTERS; k++) begin
        sum_xs[k]        <= '0;
        sum_ys[k]        <= '0;
        member_counts[k] <= '0;
      end
    end else if (cmd.pt_commit) begin
      sum_xs[best]        <= sum_xs[best] + {{PAD{pd_x[kmc_pkg::COORD_W-1]}}, pd_x};
      sum_ys[best]        <= sum_ys[best] + {{PAD{pd_y[kmc_pkg::COORD_W-1]}}, pd_y};
      member_counts[best] <= member_counts[best] + 1'b1;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit;
    end
    if (cmd.emit) begin
      point_index <= pi;
      cluster     <= no_pass ? '0 : ad;
      iterations  <= it;
      last        <= stat.pt_last;
    end
  end

endmodule

@@ hdl/kmc_ctrl.sv @@
// ----------------------------------------------------------------------------
// kmc_ctrl
// Sequencer for loads, assignment passes, center updates and result output.
// ----------------------------------------------------------------------------
module kmc_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [kmc_pkg::OP_W-1:0]    operation,
  input  kmc_pkg::stat_t              stat,
  output kmc_pkg::cmd_t               cmd,
  output logic                        busy
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_INIT   = 5'd1;
  localparam logic [4:0] S_PASS   = 5'd2;
  localparam logic [4:0] S_PRD    = 5'd3;
  localparam logic [4:0] S_PLAT   = 5'd4;
  localparam logic [4:0] S_CRD    = 5'd5;
  localparam logic [4:0] S_CDIF   = 5'd6;
  localparam logic [4:0] S_CSQ    = 5'd7;
  localparam logic [4:0] S_CSUM   = 5'd8;
  localparam logic [4:0] S_CCMP   = 5'd9;
  localparam logic [4:0] S_COMMIT = 5'd10;
  localparam logic [4:0] S_PEND   = 5'd11;
  localparam logic [4:0] S_UCHK   = 5'd12;
  localparam logic [4:0] S_DXW    = 5'd13;
  localparam logic [4:0] S_DYW    = 5'd14;
  localparam logic [4:0] S_UNXT   = 5'd15;
  localparam logic [4:0] S_ITER   = 5'd16;
  localparam logic [4:0] S_OBEG   = 5'd17;
  localparam logic [4:0] S_ORD    = 5'd18;
  localparam logic [4:0] S_OEM    = 5'd19;

  logic [4:0] state, state_next;
  logic       accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load_point  = (operation == kmc_pkg::OP_LOAD_POINT);
          cmd.load_center = (operation == kmc_pkg::OP_LOAD_CENTER);
          if (operation == kmc_pkg::OP_RUN && !stat.no_points) state_next = S_INIT;
        end
      end
      S_INIT: begin
        cmd.run_init = 1'b1;
        state_next   = stat.no_pass ? S_OBEG : S_PASS;
      end
      S_PASS: begin
        cmd.pass_begin = 1'b1;
        state_next     = S_PRD;
      end
      S_PRD: begin
        cmd.pt_read = 1'b1;
        state_next  = S_PLAT;
      end
      S_PLAT: begin
        cmd.pt_latch = 1'b1;
        state_next   = S_CRD;
      end
      S_CRD: begin
        cmd.c_read = 1'b1;
        state_next = S_CDIF;
      end
      S_CDIF: begin
        cmd.c_diff = 1'b1;
        state_next = S_CSQ;
      end
      S_CSQ: begin
        cmd.c_square = 1'b1;
        state_next   = S_CSUM;
      end
      S_CSUM: begin
        cmd.c_sum  = 1'b1;
        state_next = S_CCMP;
      end
      S_CCMP: begin
        cmd.c_compare = 1'b1;
        state_next    = (!stat.cmp_init && stat.j_end) ? S_COMMIT : S_CRD;
      end
      S_COMMIT: begin
        cmd.pt_commit = 1'b1;
        state_next    = stat.pt_last ? S_PEND : S_PRD;
      end
      S_PEND: begin
        if (stat.changed) begin
          cmd.upd_begin = 1'b1;
          state_next    = S_UCHK;
        end else begin
          state_next = S_OBEG;
        end
      end
      S_UCHK: begin
        if (stat.count_nz) begin
          cmd.div_start_x = 1'b1;
          state_next      = S_DXW;
        end else begin
          state_next = S_UNXT;
        end
      end
      S_DXW: begin
        if (stat.div_done) begin
          cmd.wr_cx       = 1'b1;
          cmd.div_start_y = 1'b1;
          state_next      = S_DYW;
        end
      end
      S_DYW: begin
        if (stat.div_done) begin
          cmd.wr_cy  = 1'b1;
          state_next = S_UNXT;
        end
      end
      S_UNXT: begin
        if (stat.j_end) begin
          state_next = S_ITER;
        end else begin
          cmd.upd_next = 1'b1;
          state_next   = S_UCHK;
        end
      end
      S_ITER: begin
        cmd.iter_inc = 1'b1;
        state_next   = stat.it_last ? S_OBEG : S_PASS;
      end
      S_OBEG: begin
        cmd.out_begin = 1'b1;
        state_next    = S_ORD;
      end
      S_ORD: begin
        cmd.pt_read = 1'b1;
        state_next  = S_OEM;
      end
      S_OEM: begin
        cmd.emit   = 1'b1;
        state_next = stat.pt_last ? S_IDLE : S_ORD;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ hdl/kmeans_2d_pruned_clustering_core.sv @@
// ----------------------------------------------------------------------------
// kmeans_2d_pruned_clustering_core
// Lloyd k-means over up to 64 loaded 2D points and 16 centers (Q16.8).
//
//  channel  | signals                                   | beat
//  ---------+-------------------------------------------+---------------------
//  command  | start, busy, operation, coord_x, coord_y  | start && !busy
//  config   | cfg_valid, cfg_ready, cfg_data            | cfg_valid && cfg_ready
//  result   | strobe, point_index, cluster,             | strobe (one cycle)
//           | iterations, last                          |
//
// Loads are taken while idle and never raise busy. A run makes passes over
// every (point, center) pair, then updates each non-empty center, x then y,
// in the serial divider; output gives one result per point.
// Reset is synchronous; no clearing pass is needed.
// The receiver cannot stall results.
// ----------------------------------------------------------------------------
module kmeans_2d_pruned_clustering_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [kmc_pkg::OP_W-1:0]            operation,
  input  logic signed [kmc_pkg::COORD_W-1:0]  coord_x,
  input  logic signed [kmc_pkg::COORD_W-1:0]  coord_y,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [kmc_pkg::ITER_W-1:0]          cfg_data,
  output logic                                strobe,
  output logic [kmc_pkg::PT_IDX_W-1:0]        point_index,
  output logic [kmc_pkg::CT_IDX_W-1:0]        cluster,
  output logic [kmc_pkg::ITER_W-1:0]          iterations,
  output logic                                last
);

  kmc_pkg::cmd_t  cmd;
  kmc_pkg::stat_t stat;

  assign cfg_ready = !busy;

  kmc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  kmc_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .strobe      (strobe),
    .point_index (point_index),
    .cluster     (cluster),
    .iterations  (iterations),
    .last        (last)
  );

`ifndef NO_ASSERTIONS
  // no two result strobes come back to back
  a_strobe_gap: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe) else $error("back-to-back result strobes");

  // the final result leaves the core idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |-> !busy) else $error("busy after last result");

  // every result is produced during a run
  a_strobe_run: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy)) else $error("result outside a run");
`endif

endmodule

@@ tb/sv/kmc_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kmc_checker
// Watches the command, config and result channels of the k-means core,
// keeps its own copy of the loaded points, centers and iteration limit,
// predicts each run's per-point cluster assignments and compares every
// result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module kmc_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic                                busy,
  input  logic [kmc_pkg::OP_W-1:0]            operation,
  input  logic signed [kmc_pkg::COORD_W-1:0]  coord_x,
  input  logic signed [kmc_pkg::COORD_W-1:0]  coord_y,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [kmc_pkg::ITER_W-1:0]          cfg_data,
  input  logic                                strobe,
  input  logic [kmc_pkg::PT_IDX_W-1:0]        point_index,
  input  logic [kmc_pkg::CT_IDX_W-1:0]        cluster,
  input  logic [kmc_pkg::ITER_W-1:0]          iterations,
  input  logic                                last,
  output int                                  fail_count,
  output int                                  pending,
  output int                                  cmd_beats,
  output int                                  run_beats,
  output int                                  result_beats
);

  typedef struct {
    logic [kmc_pkg::PT_IDX_W-1:0] idx;
    logic [kmc_pkg::CT_IDX_W-1:0] cl;
    logic [kmc_pkg::ITER_W-1:0]   iters;
    logic                         lst;
  } assign_result_t;

  // Model copy of the core's storage (centers scaled by 2^FRAC_BITS)
  longint                     pt_x [kmc_pkg::MAX_POINTS];
  longint                     pt_y [kmc_pkg::MAX_POINTS];
  longint                     ctr_x [kmc_pkg::MAX_CENTERS];
  longint                     ctr_y [kmc_pkg::MAX_CENTERS];
  int                         member_of [kmc_pkg::MAX_POINTS];
  int                         n_points;
  int                         n_centers;
  logic [kmc_pkg::ITER_W-1:0] iter_limit;
  assign_result_t             expected_assign_q [$];

  function automatic longint sq_dist(longint ax, longint ay, longint bx, longint by);
    return (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] MISMATCH %s: got %0d, want %0d", $time, what, got, want);
    fail_count++;
  endtask

  // Lloyd passes with center-gap pruning; queues one result per point
  task automatic predict_clusters();
    int     it, i, j, best, cnt [kmc_pkg::MAX_CENTERS];
    longint bd, d, px, py;
    longint sx [kmc_pkg::MAX_CENTERS], sy [kmc_pkg::MAX_CENTERS];
    longint gap [kmc_pkg::MAX_CENTERS][kmc_pkg::MAX_CENTERS];
    bit     changed;
    assign_result_t r;
    for (i = 0; i < n_points; i++) member_of[i] = 0;
    it = 0;
    if (n_centers != 0) begin
      for (it = 0; it < iter_limit; it++) begin
        changed = 0;
        for (i = 0; i < n_centers; i++)
          for (j = 0; j < n_centers; j++)
            gap[i][j] = sq_dist(ctr_x[i], ctr_y[i], ctr_x[j], ctr_y[j]);
        for (j = 0; j < n_centers; j++) begin
          sx[j] = 0; sy[j] = 0; cnt[j] = 0;
        end
        for (i = 0; i < n_points; i++) begin
          px = pt_x[i] <<< kmc_pkg::FRAC_BITS;
          py = pt_y[i] <<< kmc_pkg::FRAC_BITS;
          best = member_of[i];
          if (best >= n_centers) best = 0;
          bd = sq_dist(px, py, ctr_x[best], ctr_y[best]);
          for (j = 0; j < n_centers; j++) begin
            // skip centers too far from the current best to win
            if (bd * 4 <= gap[best][j]) continue;
            d = sq_dist(px, py, ctr_x[j], ctr_y[j]);
            if (d < bd) begin
              best = j;
              bd = d;
            end
          end
          if (member_of[i] != best) changed = 1;
          member_of[i] = best;
          sx[best] += pt_x[i];
          sy[best] += pt_y[i];
          cnt[best]++;
        end
        if (!changed) break;
        // mean update, truncated toward zero; empty clusters stay put
        for (j = 0; j < n_centers; j++)
          if (cnt[j] != 0) begin
            ctr_x[j] = (sx[j] <<< kmc_pkg::FRAC_BITS) / cnt[j];
            ctr_y[j] = (sy[j] <<< kmc_pkg::FRAC_BITS) / cnt[j];
          end
      end
    end
    for (i = 0; i < n_points; i++) begin
      r.idx   = kmc_pkg::PT_IDX_W'(i);
      r.cl    = kmc_pkg::CT_IDX_W'(member_of[i]);
      r.iters = kmc_pkg::ITER_W'(it);
      r.lst   = (i + 1 == n_points);
      expected_assign_q.push_back(r);
    end
  endtask

  // Channel monitor
  always @(posedge clk) begin
    assign_result_t want;
    if (rst) begin
      iter_limit = kmc_pkg::MAX_ITER_RESET;
      n_points   = 0;
      n_centers  = 0;
      for (int i = 0; i < kmc_pkg::MAX_POINTS; i++) member_of[i] = 0;
      expected_assign_q.delete();
      fail_count   = 0;
      cmd_beats    = 0;
      run_beats    = 0;
      result_beats = 0;
    end else begin
      if (cfg_valid && cfg_ready) iter_limit = cfg_data;
      if (start && !busy) begin
        cmd_beats++;
        case (operation)
          kmc_pkg::OP_LOAD_POINT: if (n_points < kmc_pkg::MAX_POINTS) begin
            pt_x[n_points] = coord_x;
            pt_y[n_points] = coord_y;
            n_points++;
          end
          kmc_pkg::OP_LOAD_CENTER: if (n_centers < kmc_pkg::MAX_CENTERS) begin
            ctr_x[n_centers] = longint'(coord_x) <<< kmc_pkg::FRAC_BITS;
            ctr_y[n_centers] = longint'(coord_y) <<< kmc_pkg::FRAC_BITS;
            n_centers++;
          end
          kmc_pkg::OP_RUN: begin
            run_beats++;
            if (n_points != 0) predict_clusters();
          end
          default: ;
        endcase
      end
      if (strobe) begin
        result_beats++;
        if (expected_assign_q.size() == 0) begin
          report_mismatch("unexpected result beat, point_index", point_index, -1);
        end else begin
          want = expected_assign_q.pop_front();
          if (point_index !== want.idx) report_mismatch("point_index", point_index, want.idx);
          if (cluster !== want.cl) report_mismatch("cluster", cluster, want.cl);
          if (iterations !== want.iters) report_mismatch("iterations", iterations, want.iters);
          if (last !== want.lst) report_mismatch("last", last, want.lst);
        end
      end
    end
    pending = expected_assign_q.size();
  end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the 2D k-means core: directed loads and runs at
// the coordinate and iteration-limit extremes, then random phases of point
// and center loads, noise commands and runs, sent in bursts with gaps.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [kmc_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 60;
  localparam longint CYCLE_LIMIT = 40_000_000;

  logic clk, rst, start, cfg_valid;
  logic [kmc_pkg::OP_W-1:0]           operation;
  logic signed [kmc_pkg::COORD_W-1:0] coord_x, coord_y;
  logic [kmc_pkg::ITER_W-1:0]         cfg_data;
  logic busy, cfg_ready, strobe, last;
  logic [kmc_pkg::PT_IDX_W-1:0] point_index;
  logic [kmc_pkg::CT_IDX_W-1:0] cluster;
  logic [kmc_pkg::ITER_W-1:0]   iterations;
  int fail_count, pending, cmd_beats, run_beats, result_beats;
  longint cycles;

  kmeans_2d_pruned_clustering_core u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operation(operation),
    .coord_x(coord_x), .coord_y(coord_y), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data), .strobe(strobe),
    .point_index(point_index), .cluster(cluster), .iterations(iterations),
    .last(last)
  );

  kmc_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operation(operation),
    .coord_x(coord_x), .coord_y(coord_y), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data), .strobe(strobe),
    .point_index(point_index), .cluster(cluster), .iterations(iterations),
    .last(last), .fail_count(fail_count), .pending(pending),
    .cmd_beats(cmd_beats), .run_beats(run_beats), .result_beats(result_beats)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  // One command beat; returns at the edge that accepted it
  task automatic send_cmd(logic [kmc_pkg::OP_W-1:0] op, int x, int y);
    bit acc;
    start     <= 1'b1;
    operation <= op;
    coord_x   <= 16'(x);
    coord_y   <= 16'(y);
    do begin
      @(negedge clk);
      acc = !busy;
      @(posedge clk);
    end while (!acc);
  endtask

  // Burst pacing: sometimes drop start for a random gap
  task automatic maybe_gap();
    if ($urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Wait until every predicted result has arrived, then a short pause
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(logic [kmc_pkg::ITER_W-1:0] v);
    bit acc;
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do begin
      @(negedge clk);
      acc = cfg_ready;
      @(posedge clk);
    end while (!acc);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Either full-range or clustered near one of a few spots
  function automatic int rand_coord(int spot);
    if ($urandom_range(0, 1) == 0) return $signed(16'($urandom));
    return spot + $urandom_range(0, 2000) - 1000;
  endfunction

  initial begin
    int spots [4];
    int n_pt, n_ct, k, s;
    cycles    = 0;
    rst       = 1'b1;
    start     = 1'b0;
    operation = kmc_pkg::OP_LOAD_POINT;
    coord_x   = '0;
    coord_y   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: noise, empty runs, extremes, ties, limit extremes
    send_cmd(OP_UNUSED, 16'sh7fff, -16'sh8000);
    send_cmd(kmc_pkg::OP_RUN, 0, 0);                 // no points loaded
    send_cmd(kmc_pkg::OP_LOAD_POINT, 32767, -32768);
    send_cmd(kmc_pkg::OP_LOAD_POINT, -32768, 32767);
    send_cmd(kmc_pkg::OP_LOAD_POINT, 0, 0);
    send_cmd(kmc_pkg::OP_LOAD_POINT, -1, 1);
    send_cmd(kmc_pkg::OP_RUN, 0, 0);                 // no centers loaded
    send_cmd(kmc_pkg::OP_LOAD_CENTER, -32768, -32768);
    send_cmd(kmc_pkg::OP_LOAD_CENTER, 32767, 32767);
    send_cmd(kmc_pkg::OP_LOAD_CENTER, 0, 0);
    send_cmd(kmc_pkg::OP_LOAD_CENTER, 0, 0);         // duplicate center: tie
    send_cmd(kmc_pkg::OP_RUN, 0, 0);                 // default limit
    drain();
    write_limit(16'd0);
    send_cmd(kmc_pkg::OP_RUN, 0, 0);
    drain();
    write_limit(16'hffff);
    send_cmd(kmc_pkg::OP_RUN, 0, 0);
    drain();
    write_limit(16'd1);
    send_cmd(kmc_pkg::OP_RUN, 0, 0);
    drain();

    // Random phases: loads append until the stores fill, then get ignored
    for (int ph = 0; ph < 30; ph++) begin
      for (int i = 0; i < 4; i++) spots[i] = $urandom_range(0, 60000) - 30000;
      if (ph % 6 == 5) write_limit(16'd100);
      else write_limit(16'($urandom_range(1, 5)));
      n_pt = $urandom_range(3, 10);
      n_ct = $urandom_range(0, 2);
      while (n_pt + n_ct > 0) begin
        k = $urandom_range(0, 9);
        s = spots[$urandom_range(0, 3)];
        if (k == 0) send_cmd(OP_UNUSED, $urandom, $urandom);
        else if (k <= 2 && n_ct > 0) begin
          send_cmd(kmc_pkg::OP_LOAD_CENTER, rand_coord(s), rand_coord(s));
          n_ct--;
        end else if (n_pt > 0) begin
          send_cmd(kmc_pkg::OP_LOAD_POINT, rand_coord(s), rand_coord(s));
          n_pt--;
        end
        maybe_gap();
      end
      send_cmd(kmc_pkg::OP_RUN, $urandom, $urandom);
      if ($urandom_range(0, 3) == 0) begin
        maybe_gap();
        send_cmd(kmc_pkg::OP_RUN, 0, 0);             // rerun from moved centers
      end
      drain();
    end

    $display("Sent %0d command beats including %0d runs; checked %0d result beats",
             cmd_beats, run_beats, result_beats);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/kmc_pkg.sv
hdl/kmc_divider.sv
hdl/kmc_datapath.sv
hdl/kmc_ctrl.sv
hdl/kmeans_2d_pruned_clustering_core.sv
tb/sv/kmc_checker.sv
tb/sv/tb_top.sv
